[rtl/frcp_pkg.sv]
// Shared types and fixed codes for the font ROM card command port.
package frcp_pkg;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [7:0]  port_addr;
		logic [7:0]  wr_data;
		logic [16:0] rom_addr;
	} frcp_req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       irq_raise;
		logic       irq_lower;
	} frcp_rsp_t;

	localparam logic [1:0]  REQ_WRITE    = 2'd0;
	localparam logic [1:0]  REQ_READ     = 2'd1;
	localparam logic [1:0]  REQ_ROM_LOAD = 2'd2;

	localparam logic [7:0]  DATA_PORT    = 8'hFC;
	localparam logic [7:0]  STATUS_PORT  = 8'hFD;
	localparam logic [15:0] FIRST_CODE   = 16'h0200;
	localparam logic [7:0]  REPLY_HEAD   = 8'h40;
	localparam logic [7:0]  STATUS_READY = 8'h81;
	localparam logic [7:0]  STATUS_ERROR = 8'h02;
	localparam logic [7:0]  STATUS_IDLE  = 8'h00;
	localparam logic [7:0]  OPEN_BUS     = 8'hFF;
	localparam logic [7:0]  ROM_BLANK    = 8'hFF;

endpackage

[rtl/frcp_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module frcp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/frcp_outq.sv]
// Two-entry result queue between the command logic and the result channel.
module frcp_outq
	import frcp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  frcp_rsp_t push_item,
	output logic      full,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output frcp_rsp_t rsp
);

	logic [1:0] occ_q;
	frcp_rsp_t  slot0_q;
	frcp_rsp_t  slot1_q;
	logic       pop;

	assign pop       = rsp_valid && rsp_ready;
	assign rsp_valid = (occ_q != 2'd0);
	assign full      = (occ_q == 2'd2);
	assign rsp       = slot0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 2'd0;
		end else begin
			occ_q <= occ_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push && (occ_q == 2'd0 || (occ_q == 2'd1 && pop))) begin
			slot0_q <= push_item;
		end else if (pop && occ_q == 2'd2) begin
			slot0_q <= slot1_q;
		end
		if (push && ((occ_q == 2'd1 && !pop) || (occ_q == 2'd2 && pop))) begin
			slot1_q <= push_item;
		end
	end

endmodule

[rtl/font_rom_card_command_port_top.sv]
// Each item's result is pushed into the result queue in the cycle it is accepted,
// except a data-port read of a pending reply byte, pushed after one reply RAM read.
// Most kinds are taken at one item per cycle while the result queue has room; a command
// that loads a glyph then holds the input through the copy and drain states while one
// ROM port streams into the reply RAM. Reset: control state clears at once, then a sweep
// writes 0xFF to all GLYPH_BYTES*GLYPH_COUNT ROM bytes before the first item is taken.
module font_rom_card_command_port_top
	import frcp_pkg::*;
#(
	parameter int GLYPH_BYTES = 36,
	parameter int GLYPH_COUNT = 2560
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  frcp_req_t req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output frcp_rsp_t rsp
);

	localparam int ROM_SIZE    = GLYPH_BYTES * GLYPH_COUNT;
	localparam int ROM_AW      = ROM_SIZE > 1 ? $clog2(ROM_SIZE) : 1;
	localparam int REPLY_DEPTH = GLYPH_BYTES + 1;
	localparam int RIW         = $clog2(REPLY_DEPTH);
	localparam int RCW         = $clog2(REPLY_DEPTH + 1);
	localparam int CIW         = GLYPH_BYTES > 1 ? $clog2(GLYPH_BYTES) : 1;
	localparam int GIW         = GLYPH_COUNT > 1 ? $clog2(GLYPH_COUNT) : 1;

	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_COPY   = 3'd2;
	localparam logic [2:0] ST_DRAIN  = 3'd3;
	localparam logic [2:0] ST_RDWAIT = 3'd4;

	logic [2:0]        state_q;
	logic [ROM_AW-1:0] clr_addr_q;
	logic [1:0]        cmd_cnt_q;
	logic [7:0]        cmd1_q;
	logic [ROM_AW-1:0] base_q;
	logic [CIW-1:0]    copy_i_q;
	logic              wr_s1;
	logic [RIW-1:0]    widx_s1;
	logic [RIW-1:0]    reply_idx_q;
	logic [RCW-1:0]    reply_cnt_q;
	logic [7:0]        status_q;

	logic              accept;
	logic              is_dwr;
	logic              cmd_done;
	logic              cmd_go;
	logic              drd;
	logic              drd_hit;
	logic              rom_ld;
	logic [15:0]       code_w;
	logic [15:0]       code_off;
	logic              code_ok;
	logic [ROM_AW-1:0] base_calc;

	logic              rom_we;
	logic [ROM_AW-1:0] rom_waddr;
	logic [7:0]        rom_wdata;
	logic [ROM_AW-1:0] rom_raddr;
	logic [7:0]        rom_rdata;
	logic              rep_we;
	logic [RIW-1:0]    rep_waddr;
	logic [7:0]        rep_wdata;
	logic [7:0]        rep_rdata;

	logic              q_full;
	logic              push;
	frcp_rsp_t         rsp_new;

	assign req_ready = (state_q == ST_IDLE) && !q_full;
	assign accept    = req_valid && req_ready;

	assign is_dwr   = accept && req.req_type == REQ_WRITE && req.port_addr == DATA_PORT;
	assign cmd_done = is_dwr && cmd_cnt_q == 2'd2;
	assign code_w   = {req.wr_data, cmd1_q};
	assign code_off = code_w - FIRST_CODE;
	assign code_ok  = (code_w >= FIRST_CODE)
		&& (32'(code_w) < 32'(FIRST_CODE) + GLYPH_COUNT);
	assign cmd_go   = cmd_done && code_ok;
	assign base_calc = ROM_AW'(32'(code_off[GIW-1:0]) * GLYPH_BYTES);

	assign drd     = accept && req.req_type == REQ_READ && req.port_addr == DATA_PORT;
	assign drd_hit = drd && reply_cnt_q != '0 && 32'(reply_idx_q) < REPLY_DEPTH;
	assign rom_ld  = accept && req.req_type == REQ_ROM_LOAD && 32'(req.rom_addr) < ROM_SIZE;

	// ROM: clearing sweep, byte loads, and the copy read stream
	assign rom_we    = (state_q == ST_CLEAR) || rom_ld;
	assign rom_waddr = (state_q == ST_CLEAR) ? clr_addr_q : ROM_AW'(req.rom_addr);
	assign rom_wdata = (state_q == ST_CLEAR) ? ROM_BLANK : req.wr_data;
	assign rom_raddr = base_q + ROM_AW'(copy_i_q);

	// Reply: head byte at command time, glyph bytes in the cycle after their ROM read
	assign rep_we    = cmd_go || wr_s1;
	assign rep_waddr = wr_s1 ? widx_s1 : '0;
	assign rep_wdata = wr_s1 ? rom_rdata : REPLY_HEAD;

	frcp_ram #(.WIDTH(8), .DEPTH(ROM_SIZE)) u_rom (
		.clk   (clk),
		.we    (rom_we),
		.waddr (rom_waddr),
		.wdata (rom_wdata),
		.raddr (rom_raddr),
		.rdata (rom_rdata)
	);

	frcp_ram #(.WIDTH(8), .DEPTH(REPLY_DEPTH)) u_reply (
		.clk   (clk),
		.we    (rep_we),
		.waddr (rep_waddr),
		.wdata (rep_wdata),
		.raddr (reply_idx_q),
		.rdata (rep_rdata)
	);

	assign push = (accept && !drd_hit) || (state_q == ST_RDWAIT);

	always_comb begin
		rsp_new = '0;
		if (state_q == ST_RDWAIT) begin
			rsp_new.read_data = rep_rdata;
		end else begin
			case (req.req_type)
				REQ_WRITE: begin
					if (req.port_addr == DATA_PORT) begin
						rsp_new.irq_raise = cmd_go;
					end else if (req.port_addr == STATUS_PORT) begin
						rsp_new.irq_raise = 1'b1;
					end
				end
				REQ_READ: begin
					if (req.port_addr == STATUS_PORT) begin
						rsp_new.read_data = status_q;
						rsp_new.irq_lower = 1'b1;
					end else if (req.port_addr != DATA_PORT) begin
						rsp_new.read_data = OPEN_BUS;
					end
				end
				default: begin
					rsp_new = '0;
				end
			endcase
		end
	end

	frcp_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (rsp_new),
		.full      (q_full),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			cmd_cnt_q   <= 2'd0;
			copy_i_q    <= '0;
			wr_s1       <= 1'b0;
			reply_idx_q <= '0;
			reply_cnt_q <= '0;
			status_q    <= STATUS_IDLE;
		end else begin
			wr_s1 <= (state_q == ST_COPY);
			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + ROM_AW'(1);
					if (clr_addr_q == ROM_AW'(ROM_SIZE - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (is_dwr) begin
						cmd_cnt_q <= (cmd_cnt_q == 2'd2) ? 2'd0 : cmd_cnt_q + 2'd1;
					end
					if (cmd_go) begin
						copy_i_q    <= '0;
						reply_idx_q <= '0;
						reply_cnt_q <= RCW'(REPLY_DEPTH);
						status_q    <= STATUS_READY;
						state_q     <= ST_COPY;
					end else if (cmd_done) begin
						status_q <= STATUS_ERROR;
					end
					if (drd_hit) begin
						reply_idx_q <= reply_idx_q + RIW'(1);
						reply_cnt_q <= reply_cnt_q - RCW'(1);
						if (reply_cnt_q == RCW'(1)) begin
							status_q <= STATUS_IDLE;
						end
						state_q <= ST_RDWAIT;
					end else if (drd) begin
						reply_cnt_q <= '0;
						status_q    <= STATUS_IDLE;
					end
				end
				ST_COPY: begin
					copy_i_q <= copy_i_q + CIW'(1);
					if (copy_i_q == CIW'(GLYPH_BYTES - 1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_IDLE;
				end
				ST_RDWAIT: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers: second command byte, glyph base, copy write index
	always_ff @(posedge clk) begin
		if (is_dwr && cmd_cnt_q == 2'd1) begin
			cmd1_q <= req.wr_data;
		end
		if (cmd_go) begin
			base_q <= base_calc;
		end
		widx_s1 <= RIW'(copy_i_q) + RIW'(1);
	end

	a_reply_span: assert property (@(posedge clk) disable iff (!arst_n)
		(reply_cnt_q != '0) |-> (32'(reply_idx_q) + 32'(reply_cnt_q) == REPLY_DEPTH))
		else $error("reply index and count out of step");

	a_ready_has_reply: assert property (@(posedge clk) disable iff (!arst_n)
		(status_q == STATUS_READY) |-> (reply_cnt_q != '0))
		else $error("ready status with an empty reply");

	a_copy_write_window: assert property (@(posedge clk) disable iff (!arst_n)
		wr_s1 |-> (state_q == ST_COPY || state_q == ST_DRAIN))
		else $error("reply write from copy outside the copy");

	a_rdwait_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RDWAIT) |=> (state_q == ST_IDLE))
		else $error("reply read did not complete");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR || state_q == ST_COPY) |-> !accept)
		else $error("item taken while ROM port is busy");

endmodule

[bench/font_rom_card_command_port_top_tb.sv]
// Self-checking testbench for the font ROM card command port.
`timescale 1ns / 1ps

module font_rom_card_command_port_top_tb;
	import frcp_pkg::*;

	localparam int GLYPH_BYTES = 36;
	localparam int GLYPH_COUNT = 2560;
	localparam int ROM_BYTES = GLYPH_BYTES * GLYPH_COUNT;
	localparam int REPLY_DEPTH = GLYPH_BYTES + 1;
	localparam logic [1:0] REQ_NONE = 2'd3;
	localparam logic [15:0] LAST_CODE = 16'(int'(FIRST_CODE) + GLYPH_COUNT - 1);
	localparam int ITEM_TARGET = 1750;
	localparam int WATCHDOG_LIMIT = 500000;

	class glyph_reply_predictor;
		bit [7:0] glyph_rom [ROM_BYTES];
		bit [7:0] command_bytes [3];
		int unsigned command_count;
		bit [7:0] reply_bytes [REPLY_DEPTH];
		int unsigned reply_index;
		int unsigned reply_left;
		bit [7:0] status_byte;
		frcp_rsp_t pending_responses[$];
		int unsigned failures;

		function new();
			foreach (glyph_rom[i]) glyph_rom[i] = ROM_BLANK;
			command_count = 0;
			reply_index = 0;
			reply_left = 0;
			status_byte = STATUS_IDLE;
			failures = 0;
		endfunction

		// Returns 1 when the command loads a glyph and raises the interrupt.
		function bit start_glyph_fetch();
			logic [15:0] code;
			int base;
			code = {command_bytes[2], command_bytes[1]};
			if (code < FIRST_CODE || int'(code) >= int'(FIRST_CODE) + GLYPH_COUNT) begin
				status_byte = STATUS_ERROR;
				return 1'b0;
			end
			base = (int'(code) - int'(FIRST_CODE)) * GLYPH_BYTES;
			reply_bytes[0] = REPLY_HEAD;
			for (int i = 0; i < GLYPH_BYTES; i++)
				reply_bytes[i + 1] = glyph_rom[base + i];
			reply_index = 0;
			reply_left = REPLY_DEPTH;
			status_byte = STATUS_READY;
			return 1'b1;
		endfunction

		function void apply_request(frcp_req_t item);
			frcp_rsp_t exp_rsp;
			exp_rsp = '0;
			case (item.req_type)
				REQ_WRITE: begin
					if (item.port_addr == DATA_PORT) begin
						command_bytes[command_count] = item.wr_data;
						command_count++;
						if (command_count == 3) begin
							command_count = 0;
							exp_rsp.irq_raise = start_glyph_fetch();
						end
					end else if (item.port_addr == STATUS_PORT) begin
						exp_rsp.irq_raise = 1'b1;
					end
				end
				REQ_READ: begin
					if (item.port_addr == DATA_PORT) begin
						if (reply_left != 0) begin
							exp_rsp.read_data = reply_bytes[reply_index];
							reply_index++;
							reply_left--;
						end
						if (reply_left == 0) status_byte = STATUS_IDLE;
					end else if (item.port_addr == STATUS_PORT) begin
						exp_rsp.read_data = status_byte;
						exp_rsp.irq_lower = 1'b1;
					end else begin
						exp_rsp.read_data = OPEN_BUS;
					end
				end
				REQ_ROM_LOAD: begin
					if (item.rom_addr < ROM_BYTES) glyph_rom[item.rom_addr] = item.wr_data;
				end
				default: ;
			endcase
			pending_responses.push_back(exp_rsp);
		endfunction

		function void compare_response(frcp_rsp_t got);
			frcp_rsp_t exp_rsp;
			if (pending_responses.size() == 0) begin
				$error("response with none pending: read_data %0h irq_raise %0b irq_lower %0b",
					got.read_data, got.irq_raise, got.irq_lower);
				failures++;
				return;
			end
			exp_rsp = pending_responses.pop_front();
			if (got.read_data !== exp_rsp.read_data) begin
				$error("read_data: expected %0h, got %0h", exp_rsp.read_data, got.read_data);
				failures++;
			end
			if (got.irq_raise !== exp_rsp.irq_raise) begin
				$error("irq_raise: expected %0b, got %0b", exp_rsp.irq_raise, got.irq_raise);
				failures++;
			end
			if (got.irq_lower !== exp_rsp.irq_lower) begin
				$error("irq_lower: expected %0b, got %0b", exp_rsp.irq_lower, got.irq_lower);
				failures++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	frcp_req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	frcp_rsp_t rsp;

	glyph_reply_predictor sb;
	int send_idle_pct = 6;
	int recv_idle_pct = 67;
	int items_sent = 0;
	int quiet_cycles = 0;

	font_rom_card_command_port_top #(
		.GLYPH_BYTES(GLYPH_BYTES),
		.GLYPH_COUNT(GLYPH_COUNT)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Predict on accepted requests before checking responses taken at the same edge.
	always @(posedge clk) begin
		if (arst_n && req_valid && req_ready) sb.apply_request(req);
		if (arst_n && rsp_valid && rsp_ready) sb.compare_response(rsp);
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin : watchdog
		while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
		$display("simulation failed");
		$finish;
	end

	function automatic frcp_req_t make_req(logic [1:0] kind, logic [7:0] port,
		logic [7:0] data, logic [16:0] raddr);
		frcp_req_t item;
		item.req_type = kind;
		item.port_addr = port;
		item.wr_data = data;
		item.rom_addr = raddr;
		return item;
	endfunction

	task automatic send_item(input frcp_req_t item);
		if ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		req <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		items_sent++;
	endtask

	task automatic send_command(input logic [7:0] mode, input logic [15:0] code);
		send_item(make_req(REQ_WRITE, DATA_PORT, mode, 17'($urandom_range(17'h1FFFF))));
		send_item(make_req(REQ_WRITE, DATA_PORT, code[7:0], 17'($urandom_range(17'h1FFFF))));
		send_item(make_req(REQ_WRITE, DATA_PORT, code[15:8], 17'($urandom_range(17'h1FFFF))));
	endtask

	// Hold off new items until every pending response has come back.
	task automatic drain_responses();
		req_valid <= 1'b0;
		do @(posedge clk); while (sb.pending_responses.size() != 0);
	endtask

	initial begin
		logic [15:0] code;
		logic [7:0] port;
		int pick;
		int glyph_base;
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: status and empty reply, open ports, unknown kind, ROM address limits,
		// codes just outside and at both ends of the glyph range.
		send_item(make_req(REQ_READ, STATUS_PORT, 8'h00, 17'h00000));
		send_item(make_req(REQ_READ, DATA_PORT, 8'h00, 17'h00000));
		send_item(make_req(REQ_WRITE, STATUS_PORT, 8'hFF, 17'h1FFFF));
		send_item(make_req(REQ_READ, 8'hFF, 8'h00, 17'h00000));
		send_item(make_req(REQ_WRITE, 8'h00, 8'hFF, 17'h00000));
		send_item(make_req(REQ_NONE, 8'hFF, 8'hFF, 17'h1FFFF));
		send_item(make_req(REQ_ROM_LOAD, 8'h00, 8'h00, 17'd0));
		send_item(make_req(REQ_ROM_LOAD, 8'hFF, 8'hA5, 17'(ROM_BYTES - 1)));
		send_item(make_req(REQ_ROM_LOAD, 8'h00, 8'h3C, 17'(ROM_BYTES)));
		send_item(make_req(REQ_ROM_LOAD, 8'h00, 8'h3C, 17'h1FFFF));
		send_command(8'hFF, FIRST_CODE - 16'd1);
		send_command(8'h00, LAST_CODE + 16'd1);
		send_item(make_req(REQ_READ, STATUS_PORT, 8'h00, 17'h00000));
		send_command(8'h5A, FIRST_CODE);
		repeat (2) send_item(make_req(REQ_READ, DATA_PORT, 8'h00, 17'h00000));
		send_item(make_req(REQ_READ, STATUS_PORT, 8'h00, 17'h00000));
		send_command(8'hA5, LAST_CODE);
		send_item(make_req(REQ_READ, DATA_PORT, 8'h00, 17'h00000));

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 67 : 0;
			recv_idle_pct = (phase == 0) ? 67 : (phase == 1) ? 6 : 0;
			while (items_sent < (phase + 1) * ITEM_TARGET / 3) begin
				pick = $urandom_range(99);
				if (pick < 75) begin
					pick = $urandom_range(99);
					if (pick < 10)
						code = FIRST_CODE;
					else if (pick < 20)
						code = LAST_CODE;
					else if (pick < 80)
						code = FIRST_CODE + 16'($urandom_range(GLYPH_COUNT - 1));
					else
						code = 16'($urandom_range(16'hFFFF));
					if (code >= FIRST_CODE && code <= LAST_CODE && $urandom_range(1)) begin
						glyph_base = (int'(code) - int'(FIRST_CODE)) * GLYPH_BYTES;
						repeat ($urandom_range(1, 6))
							send_item(make_req(REQ_ROM_LOAD, 8'($urandom_range(255)),
								8'($urandom_range(255)),
								17'(glyph_base + int'($urandom_range(GLYPH_BYTES - 1)))));
					end
					// Realign the command bytes most of the time; leave some sequences broken.
					if ($urandom_range(99) < 80)
						repeat ((3 - sb.command_count) % 3)
							send_item(make_req(REQ_WRITE, DATA_PORT, 8'($urandom_range(255)),
								17'($urandom_range(17'h1FFFF))));
					send_command(8'($urandom_range(255)), code);
					repeat ($urandom_range(40)) begin
						pick = $urandom_range(99);
						if (pick < 8)
							send_item(make_req(REQ_READ, STATUS_PORT, 8'($urandom_range(255)),
								17'($urandom_range(17'h1FFFF))));
						else if (pick < 11)
							send_item(make_req(REQ_WRITE, STATUS_PORT, 8'($urandom_range(255)),
								17'($urandom_range(17'h1FFFF))));
						else
							send_item(make_req(REQ_READ, DATA_PORT, 8'($urandom_range(255)),
								17'($urandom_range(17'h1FFFF))));
					end
				end else begin
					pick = $urandom_range(99);
					port = (pick < 40) ? DATA_PORT : (pick < 70) ? STATUS_PORT :
						8'($urandom_range(255));
					send_item(make_req(2'($urandom_range(3)), port, 8'($urandom_range(255)),
						17'($urandom_range(17'h1FFFF))));
				end
				if ($urandom_range(99) < 2) drain_responses();
			end
			drain_responses();
		end
		repeat (4) @(posedge clk);

		if (sb.pending_responses.size() != 0) begin
			$error("%0d responses never arrived", sb.pending_responses.size());
			sb.failures++;
		end
		if (sb.failures == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
